@@ hw/rtl/iir4_pkg.sv @@
// ----------------------------------------------------------------------------
// iir4_pkg
// Shared widths, register codes, reset values, control types and the
// saturating Q15/Q31 helpers of the fourth-order IIR filter.
// ----------------------------------------------------------------------------
`default_nettype none

package iir4_pkg;

    localparam int SAMPLE_W = 16;
    localparam int ACC_W    = 32;
    localparam int DIGIT_W  = 4;
    localparam int DIGITS   = SAMPLE_W / DIGIT_W;
    localparam int STEP_W   = $clog2(DIGITS);
    localparam int PP_W     = SAMPLE_W + DIGIT_W + 1;
    localparam int LO_W     = SAMPLE_W - DIGIT_W;
    localparam int CFG_IDX_W = 3;
    localparam int TERM_W    = 4;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [ACC_W-1:0]    t_acc;
    typedef logic [CFG_IDX_W-1:0]       t_cfg_idx;
    typedef logic [TERM_W-1:0]          t_term;

    localparam t_cfg_idx REG_NUM_OUTER  = 3'd0;
    localparam t_cfg_idx REG_NUM_INNER  = 3'd1;
    localparam t_cfg_idx REG_NUM_CENTER = 3'd2;
    localparam t_cfg_idx REG_DEN_FIRST  = 3'd3;
    localparam t_cfg_idx REG_DEN_SECOND = 3'd4;
    localparam t_cfg_idx REG_DEN_THIRD  = 3'd5;
    localparam t_cfg_idx REG_DEN_FOURTH = 3'd6;

    localparam t_sample RST_NUM_OUTER  = 16'sd1170;
    localparam t_sample RST_NUM_INNER  = 16'sd39;
    localparam t_sample RST_NUM_CENTER = 16'sd1891;
    localparam t_sample RST_DEN_FIRST  = 16'sd26401;
    localparam t_sample RST_DEN_SECOND = 16'sd30783;
    localparam t_sample RST_DEN_THIRD  = 16'sd16132;
    localparam t_sample RST_DEN_FOURTH = 16'sd5043;

    localparam t_term TERM_FB_D1   = 4'd0;
    localparam t_term TERM_FB_D2   = 4'd1;
    localparam t_term TERM_FB_D3   = 4'd2;
    localparam t_term TERM_FB_D4   = 4'd3;
    localparam t_term TERM_FF_W    = 4'd4;
    localparam t_term TERM_FF_D1   = 4'd5;
    localparam t_term TERM_FF_D2   = 4'd6;
    localparam t_term TERM_FF_D3   = 4'd7;
    localparam t_term TERM_FF_D4   = 4'd8;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_ACC  = 5'b00100,
        S_W    = 5'b01000,
        S_Y    = 5'b10000
    } t_state;

    typedef struct packed {
        logic init;
        logic clr;
        logic step;
        logic sub;
    } t_acc_ctl;

    function automatic t_acc sat_add(input t_acc a, input t_acc b, input logic sub);
        logic signed [ACC_W:0] s;
        t_acc                  r;
        if (sub) begin
            s = {a[ACC_W-1], a} - {b[ACC_W-1], b};
        end else begin
            s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        end
        if (s[ACC_W] != s[ACC_W-1]) begin
            r = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            r = s[ACC_W-1:0];
        end
        return r;
    endfunction

    function automatic t_acc frac_dbl(input t_acc p);
        t_acc r;
        if (p[ACC_W-1] != p[ACC_W-2]) begin
            r = p[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            r = {p[ACC_W-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic t_sample round_dbl(input t_acc a);
        t_acc    r;
        t_sample hi;
        t_sample q;
        r  = sat_add(a, t_acc'(32'sh0000_8000), 1'b0);
        hi = r[ACC_W-1:ACC_W-SAMPLE_W];
        if (hi[SAMPLE_W-1] != hi[SAMPLE_W-2]) begin
            q = hi[SAMPLE_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                               : {1'b0, {(SAMPLE_W-1){1'b1}}};
        end else begin
            q = {hi[SAMPLE_W-2:0], 1'b0};
        end
        return q;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/iir_fourth_order_df2_q15.sv @@
// ----------------------------------------------------------------------------
// iir_fourth_order_df2_q15
// Fourth-order direct form II IIR filter on signed Q15 samples.
//
// Input channel: i_in_valid / o_in_stall with i_sample_in; a transfer takes
// place when valid is high and stall is low. Output channel: o_out_valid /
// i_out_stall with o_sample_out, one result per input sample.
// Coefficients are written through i_cfg_we / i_cfg_index / i_cfg_data;
// the user must write them only while the filter is idle, as the block
// itself does not enforce it; indexes beyond the list are dropped.
// Each sample runs nine products through one digit-serial multiplier,
// each followed by handover and accumulation; a new sample is taken only
// once the result is loaded. o_in_stall is high while a sample is in work.
// A finished result waits in the output register; a new sample is accepted
// meanwhile, but its own result holds until the receiver drops stall.
// Reset restores the default coefficients and clears the delay line.
// ----------------------------------------------------------------------------
`default_nettype none

module iir_fourth_order_df2_q15 (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic signed [15:0]             i_sample_in,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic signed [15:0]                  o_sample_out,
    input  wire logic                           i_cfg_we,
    input  wire logic [iir4_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [15:0]                    i_cfg_data
);

    iir4_pkg::t_state  r_state, n_state;
    iir4_pkg::t_term   r_term, n_term;
    iir4_pkg::t_term   sel;
    iir4_pkg::t_sample r_num_outer, r_num_inner, r_num_center;
    iir4_pkg::t_sample r_den_first, r_den_second, r_den_third, r_den_fourth;
    iir4_pkg::t_sample r_d1, r_d2, r_d3, r_d4;
    iir4_pkg::t_sample r_w;
    iir4_pkg::t_sample r_out;
    logic              r_out_valid;

    logic               in_xfer;
    logic               out_free;
    logic               mul_start;
    logic               mul_done;
    iir4_pkg::t_acc     mul_prod;
    iir4_pkg::t_sample  op_a, op_b;
    iir4_pkg::t_acc_ctl acc_ctl;
    iir4_pkg::t_sample  acc_rnd;
    logic               y_load;

    assign in_xfer  = i_in_valid && (r_state == iir4_pkg::S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state   = r_state;
        n_term    = r_term;
        sel       = r_term;
        mul_start = 1'b0;
        acc_ctl   = '0;
        y_load    = 1'b0;
        unique case (r_state)
            iir4_pkg::S_IDLE: begin
                sel = iir4_pkg::TERM_FB_D1;
                if (in_xfer) begin
                    acc_ctl.init = 1'b1;
                    mul_start    = 1'b1;
                    n_term       = iir4_pkg::TERM_FB_D1;
                    n_state      = iir4_pkg::S_MUL;
                end
            end
            iir4_pkg::S_MUL: begin
                if (mul_done) begin
                    n_state = iir4_pkg::S_ACC;
                end
            end
            iir4_pkg::S_ACC: begin
                acc_ctl.step = 1'b1;
                acc_ctl.sub  = (r_term < iir4_pkg::TERM_FF_W);
                sel          = r_term + 1'b1;
                priority if (r_term == iir4_pkg::TERM_FB_D4) begin
                    n_state = iir4_pkg::S_W;
                end else if (r_term == iir4_pkg::TERM_FF_D4) begin
                    n_state = iir4_pkg::S_Y;
                end else begin
                    mul_start = 1'b1;
                    n_term    = r_term + 1'b1;
                    n_state   = iir4_pkg::S_MUL;
                end
            end
            iir4_pkg::S_W: begin
                sel         = iir4_pkg::TERM_FF_W;
                acc_ctl.clr = 1'b1;
                mul_start   = 1'b1;
                n_term      = iir4_pkg::TERM_FF_W;
                n_state     = iir4_pkg::S_MUL;
            end
            iir4_pkg::S_Y: begin
                if (out_free) begin
                    y_load  = 1'b1;
                    n_state = iir4_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = iir4_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        unique case (sel)
            iir4_pkg::TERM_FB_D1: begin op_a = r_den_first;  op_b = r_d1; end
            iir4_pkg::TERM_FB_D2: begin op_a = r_den_second; op_b = r_d2; end
            iir4_pkg::TERM_FB_D3: begin op_a = r_den_third;  op_b = r_d3; end
            iir4_pkg::TERM_FB_D4: begin op_a = r_den_fourth; op_b = r_d4; end
            iir4_pkg::TERM_FF_W:  begin op_a = r_num_outer;  op_b = acc_rnd; end
            iir4_pkg::TERM_FF_D1: begin op_a = r_num_inner;  op_b = r_d1; end
            iir4_pkg::TERM_FF_D2: begin op_a = r_num_center; op_b = r_d2; end
            iir4_pkg::TERM_FF_D3: begin op_a = r_num_inner;  op_b = r_d3; end
            iir4_pkg::TERM_FF_D4: begin op_a = r_num_outer;  op_b = r_d4; end
            default:              begin op_a = '0;           op_b = '0;   end
        endcase
    end

    iir4_dsmul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (op_a),
        .i_b     (op_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    iir4_sacc u_acc (
        .i_clk  (i_clk),
        .i_ctl  (acc_ctl),
        .i_x    (i_sample_in),
        .i_prod (mul_prod),
        .o_rnd  (acc_rnd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= iir4_pkg::S_IDLE;
            r_term       <= iir4_pkg::TERM_FB_D1;
            r_out_valid  <= 1'b0;
            r_num_outer  <= iir4_pkg::RST_NUM_OUTER;
            r_num_inner  <= iir4_pkg::RST_NUM_INNER;
            r_num_center <= iir4_pkg::RST_NUM_CENTER;
            r_den_first  <= iir4_pkg::RST_DEN_FIRST;
            r_den_second <= iir4_pkg::RST_DEN_SECOND;
            r_den_third  <= iir4_pkg::RST_DEN_THIRD;
            r_den_fourth <= iir4_pkg::RST_DEN_FOURTH;
            r_d1         <= '0;
            r_d2         <= '0;
            r_d3         <= '0;
            r_d4         <= '0;
        end else begin
            r_state <= n_state;
            r_term  <= n_term;
            if (y_load) begin
                r_out_valid <= 1'b1;
                r_d1        <= r_w;
                r_d2        <= r_d1;
                r_d3        <= r_d2;
                r_d4        <= r_d3;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    iir4_pkg::REG_NUM_OUTER:  r_num_outer  <= i_cfg_data;
                    iir4_pkg::REG_NUM_INNER:  r_num_inner  <= i_cfg_data;
                    iir4_pkg::REG_NUM_CENTER: r_num_center <= i_cfg_data;
                    iir4_pkg::REG_DEN_FIRST:  r_den_first  <= i_cfg_data;
                    iir4_pkg::REG_DEN_SECOND: r_den_second <= i_cfg_data;
                    iir4_pkg::REG_DEN_THIRD:  r_den_third  <= i_cfg_data;
                    iir4_pkg::REG_DEN_FOURTH: r_den_fourth <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == iir4_pkg::S_W) begin
            r_w <= acc_rnd;
        end
        if (y_load) begin
            r_out <= acc_rnd;
        end
    end

    assign o_in_stall   = (r_state != iir4_pkg::S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out;

endmodule

`default_nettype wire

@@ hw/rtl/iir4_dsmul.sv @@
// ----------------------------------------------------------------------------
// iir4_dsmul
// Digit-serial signed 16x16 multiplier: the multiplier operand shifts out
// four bits per cycle, the partial sum shifts right into a low register.
// ----------------------------------------------------------------------------
`default_nettype none

module iir4_dsmul (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire iir4_pkg::t_sample i_a,
    input  wire iir4_pkg::t_sample i_b,
    output logic                  o_done,
    output iir4_pkg::t_acc        o_prod
);

    logic                                r_busy;
    logic [iir4_pkg::STEP_W-1:0]         r_step;
    logic                                r_done;
    iir4_pkg::t_sample                   r_a;
    logic [iir4_pkg::SAMPLE_W-1:0]       r_b;
    logic signed [iir4_pkg::PP_W-1:0]    r_hi;
    logic [iir4_pkg::LO_W-1:0]           r_lo;
    iir4_pkg::t_acc                      r_prod;

    logic                                last;
    logic signed [iir4_pkg::DIGIT_W:0]   digit;
    logic signed [iir4_pkg::PP_W-1:0]    pp;
    logic signed [iir4_pkg::PP_W-1:0]    n_sum;

    assign last = (r_step == iir4_pkg::STEP_W'(iir4_pkg::DIGITS - 1));

    always_comb begin
        if (last) begin
            digit = {r_b[iir4_pkg::DIGIT_W-1], r_b[iir4_pkg::DIGIT_W-1:0]};
        end else begin
            digit = {1'b0, r_b[iir4_pkg::DIGIT_W-1:0]};
        end
        pp    = iir4_pkg::PP_W'(r_a) * iir4_pkg::PP_W'(digit);
        n_sum = r_hi + pp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a  <= i_a;
            r_b  <= i_b;
            r_hi <= '0;
        end else if (r_busy) begin
            r_b  <= r_b >> iir4_pkg::DIGIT_W;
            r_hi <= n_sum >>> iir4_pkg::DIGIT_W;
            r_lo <= {n_sum[iir4_pkg::DIGIT_W-1:0], r_lo[iir4_pkg::LO_W-1:iir4_pkg::DIGIT_W]};
            if (last) begin
                r_prod <= {n_sum[iir4_pkg::ACC_W-iir4_pkg::LO_W-1:0], r_lo};
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;

endmodule

`default_nettype wire

@@ hw/rtl/iir4_sacc.sv @@
// ----------------------------------------------------------------------------
// iir4_sacc
// Saturating Q31 accumulator: loads the halved sample or zero, adds or
// subtracts doubled products, and presents the rounded, doubled Q15 value.
// ----------------------------------------------------------------------------
`default_nettype none

module iir4_sacc (
    input  wire logic              i_clk,
    input  wire iir4_pkg::t_acc_ctl i_ctl,
    input  wire iir4_pkg::t_sample  i_x,
    input  wire iir4_pkg::t_acc     i_prod,
    output iir4_pkg::t_sample       o_rnd
);

    iir4_pkg::t_acc r_acc;
    iir4_pkg::t_acc n_acc;

    always_comb begin
        priority if (i_ctl.init) begin
            n_acc = {i_x[iir4_pkg::SAMPLE_W-1], i_x[iir4_pkg::SAMPLE_W-1:1],
                     {(iir4_pkg::ACC_W-iir4_pkg::SAMPLE_W){1'b0}}};
        end else if (i_ctl.clr) begin
            n_acc = '0;
        end else if (i_ctl.step) begin
            n_acc = iir4_pkg::sat_add(r_acc, iir4_pkg::frac_dbl(i_prod), i_ctl.sub);
        end else begin
            n_acc = r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_rnd = iir4_pkg::round_dbl(r_acc);

endmodule

`default_nettype wire
